// ----- sv/rstok_pkg.sv -----
// Shared types, constants and event codes for the RESP stream tokenizer.
package rstok_pkg;

  // Default nesting depth of the array stack.
  localparam int unsigned NEST_DEPTH_DEF = 8;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned CNT_W   = 31;
  localparam int unsigned BULK_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARRAY  = 2'd2;

  // Event codes.
  localparam logic [EVENT_W-1:0] EV_STR_BYTE  = 4'd0;
  localparam logic [EVENT_W-1:0] EV_ERR_BYTE  = 4'd1;
  localparam logic [EVENT_W-1:0] EV_BULK_BYTE = 4'd2;
  localparam logic [EVENT_W-1:0] EV_STR_END   = 4'd3;
  localparam logic [EVENT_W-1:0] EV_ERR_END   = 4'd4;
  localparam logic [EVENT_W-1:0] EV_BULK_END  = 4'd5;
  localparam logic [EVENT_W-1:0] EV_INT       = 4'd6;
  localparam logic [EVENT_W-1:0] EV_BULK_LEN  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_NULL      = 4'd8;
  localparam logic [EVENT_W-1:0] EV_ARRAY     = 4'd9;
  localparam logic [EVENT_W-1:0] EV_BAD       = 4'd10;

  // Protocol characters.
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Command from the parser to the nesting stack.
  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic [CNT_W-1:0] count;
  } stk_cmd_t;

endpackage

// ----- sv/rstok_stack.sv -----
// Stack of remaining array element counts, with the pop search for a finished element.
module rstok_stack #(
  parameter int unsigned NestDepth = rstok_pkg::NEST_DEPTH_DEF,
  localparam int unsigned LvlW = $clog2(NestDepth + 1),
  localparam int unsigned IdxW = (NestDepth > 1) ? $clog2(NestDepth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rstok_pkg::stk_cmd_t cmd_i,
  output logic [LvlW-1:0]     lvl_o,
  output logic                fin_o
);
  import rstok_pkg::*;

  logic [CNT_W-1:0] cnt_q [NestDepth];
  logic [LvlW-1:0]  lvl_q, lvl_d, lvl_eff;
  logic             found;
  logic [IdxW-1:0]  sel;

  // Find the innermost open array that does not close with this element.
  always_comb begin
    lvl_eff = cmd_i.clear ? '0 : lvl_q;
    found   = 1'b0;
    sel     = '0;
    for (int i = 0; i < NestDepth; i++) begin
      if ((LvlW'(i) < lvl_eff) && (cnt_q[i] != CNT_W'(1))) begin
        found = 1'b1;
        sel   = IdxW'(i);
      end
    end
    fin_o = !found;
    lvl_o = lvl_eff;
    if (cmd_i.push) begin
      lvl_d = lvl_eff + LvlW'(1);
    end else if (cmd_i.pop) begin
      lvl_d = found ? (LvlW'(sel) + LvlW'(1)) : '0;
    end else begin
      lvl_d = lvl_eff;
    end
  end

  // Nesting level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else begin
      lvl_q <= lvl_d;
    end
  end

  // Count storage: a push writes the new top, a pop decrements the surviving level.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      cnt_q[lvl_eff[IdxW-1:0]] <= cmd_i.count;
    end else if (cmd_i.pop && found) begin
      cnt_q[sel] <= cnt_q[sel] - CNT_W'(1);
    end
  end

endmodule

// ----- sv/resp_stream_tokenizer_top.sv -----
// Top level of the RESP stream tokenizer: input register, parser and result register.
// A beat is held in the input register and parsed, and its event is held in the result register.
// Throughput: one byte per cycle while the output is not stalled; the parse step and the stack
// pop search are combinational. A byte that gives no event is still consumed.
// Reset (asynchronous, active low) empties both registers, restarts the parse and
// loads the limit registers with their defaults; no clearing pass is needed.
module resp_stream_tokenizer_top #(
  parameter int unsigned NestDepth = rstok_pkg::NEST_DEPTH_DEF,
  localparam int unsigned LvlW = $clog2(NestDepth + 1)
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                s_axis_tvalid,
  output logic                                                s_axis_tready,
  input  logic [rstok_pkg::BYTE_W-1:0]                        s_axis_tdata,  // data_byte
  input  logic                                                s_axis_tuser,  // start_of_message
  output logic                                                m_axis_tvalid,
  input  logic                                                m_axis_tready,
  // event_res [3:0], value [67:4], depth [71:68]
  output logic [rstok_pkg::EVENT_W+rstok_pkg::VALUE_W+rstok_pkg::DEPTH_W-1:0] m_axis_tdata,
  output logic                                                m_axis_tlast,  // last
  input  logic                                                cfg_valid_i,
  output logic                                                cfg_ready_o,
  input  logic [rstok_pkg::CFG_IDX_W-1:0]                     cfg_index_i,
  input  logic [rstok_pkg::CFG_DATA_W-1:0]                    cfg_data_i
);
  import rstok_pkg::*;

  localparam int unsigned OutW = EVENT_W + VALUE_W + DEPTH_W;
  localparam logic [VALUE_W-1:0] MagCap = {1'b1, {(VALUE_W-1){1'b0}}};

  // Parse phases.
  localparam logic [2:0] PH_TYPE      = 3'd0;
  localparam logic [2:0] PH_SIMPLE    = 3'd1;
  localparam logic [2:0] PH_SIMPLE_LF = 3'd2;
  localparam logic [2:0] PH_NUM       = 3'd3;
  localparam logic [2:0] PH_NUM_LF    = 3'd4;
  localparam logic [2:0] PH_BULK      = 3'd5;
  localparam logic [2:0] PH_SKIP1     = 3'd6;
  localparam logic [2:0] PH_SKIP2     = 3'd7;

  // Element kinds.
  localparam logic [2:0] K_STR  = 3'd0;
  localparam logic [2:0] K_ERR  = 3'd1;
  localparam logic [2:0] K_INT  = 3'd2;
  localparam logic [2:0] K_BULK = 3'd3;
  localparam logic [2:0] K_ARR  = 3'd4;

  // Limit registers.
  logic [BYTE_W-1:0] max_simple_q;
  logic [BULK_W-1:0] max_bulk_q;
  logic [CNT_W-1:0]  max_array_q;

  // Input register.
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_sof_q;

  // Parse state.
  logic [2:0]         phase_q, phase_d;
  logic [2:0]         kind_q, kind_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               neg_q, neg_d;
  logic               dig_q, dig_d;
  logic [BYTE_W-1:0]  cc_q, cc_d;
  logic [BULK_W-1:0]  rem_q, rem_d;
  logic               done_q, done_d;
  logic               lock_q, lock_d;

  // Result register.
  logic               out_vld_q;
  logic [OutW-1:0]    out_data_q;
  logic               out_last_q;

  logic               proc;
  logic               emit;
  logic [EVENT_W-1:0] ev;
  logic [VALUE_W-1:0] val;
  logic               lst;
  logic [DEPTH_W-1:0] dep;
  logic [2:0]         phase_e;
  logic [VALUE_W+3:0] acc_ten;
  logic [VALUE_W-1:0] mag;
  logic               mag_neg;
  logic [BULK_W-1:0]  rem_dec;
  stk_cmd_t           cmd;
  logic [LvlW-1:0]    lvl;
  logic               fin;

  assign proc          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  rstok_stack #(.NestDepth(NestDepth)) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .lvl_o  (lvl),
    .fin_o  (fin)
  );

  // Decimal step and finished-number terms.
  always_comb begin
    acc_ten = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
            + (VALUE_W+4)'(in_byte_q - CH_ZERO);
    mag     = acc_q;
    mag_neg = neg_q && (acc_q != '0);
    rem_dec = (rem_q != '0) ? (rem_q - BULK_W'(1)) : rem_q;
  end

  // One parse step per byte.
  always_comb begin
    phase_e = in_sof_q ? PH_TYPE : phase_q;
    phase_d = phase_e;
    kind_d  = kind_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    dig_d   = dig_q;
    cc_d    = cc_q;
    rem_d   = rem_q;
    done_d  = in_sof_q ? 1'b0 : done_q;
    lock_d  = in_sof_q ? 1'b0 : lock_q;
    cmd       = '0;
    cmd.clear = in_sof_q;
    emit = 1'b0;
    ev   = EV_BAD;
    val  = '0;
    lst  = 1'b0;
    dep  = DEPTH_W'(lvl);

    if (!lock_d && !done_d) begin
      case (phase_e)
        PH_TYPE: begin
          cc_d  = '0;
          acc_d = '0;
          neg_d = 1'b0;
          dig_d = 1'b0;
          if (in_byte_q == CH_PLUS || in_byte_q == CH_MINUS) begin
            kind_d  = (in_byte_q == CH_PLUS) ? K_STR : K_ERR;
            phase_d = PH_SIMPLE;
          end else if (in_byte_q == CH_COLON) begin
            kind_d  = K_INT;
            phase_d = PH_NUM;
          end else if (in_byte_q == CH_DOLLAR) begin
            kind_d  = K_BULK;
            phase_d = PH_NUM;
          end else if (in_byte_q == CH_STAR) begin
            kind_d  = K_ARR;
            phase_d = PH_NUM;
          end else begin
            emit   = 1'b1;
            lock_d = 1'b1;
          end
        end
        PH_SIMPLE: begin
          if (in_byte_q == CH_CR) begin
            if (cc_q == '0) begin
              emit   = 1'b1;
              lock_d = 1'b1;
            end else begin
              phase_d = PH_SIMPLE_LF;
            end
          end else if (in_byte_q == CH_LF) begin
            emit   = 1'b1;
            lock_d = 1'b1;
          end else begin
            if (cc_q != '1) begin
              cc_d = cc_q + BYTE_W'(1);
            end
            if (cc_q < max_simple_q) begin
              emit = 1'b1;
              ev   = (kind_q == K_ERR) ? EV_ERR_BYTE : EV_STR_BYTE;
              val  = VALUE_W'(in_byte_q);
            end
          end
        end
        PH_SIMPLE_LF: begin
          emit = 1'b1;
          if (in_byte_q != CH_LF) begin
            lock_d = 1'b1;
          end else begin
            ev      = (kind_q == K_ERR) ? EV_ERR_END : EV_STR_END;
            lst     = fin;
            cmd.pop = 1'b1;
            done_d  = fin;
            phase_d = PH_TYPE;
          end
        end
        PH_NUM: begin
          if (in_byte_q >= CH_ZERO && in_byte_q <= CH_NINE) begin
            acc_d = (acc_ten > (VALUE_W+4)'(MagCap)) ? MagCap : acc_ten[VALUE_W-1:0];
            dig_d = 1'b1;
          end else if (in_byte_q == CH_MINUS && !dig_q && !neg_q) begin
            neg_d = 1'b1;
          end else if (in_byte_q == CH_CR && dig_q) begin
            phase_d = PH_NUM_LF;
          end else begin
            emit   = 1'b1;
            lock_d = 1'b1;
          end
        end
        PH_NUM_LF: begin
          emit = 1'b1;
          if (in_byte_q != CH_LF) begin
            lock_d = 1'b1;
          end else if (kind_q == K_INT) begin
            ev      = EV_INT;
            val     = mag_neg ? (VALUE_W'(0) - mag)
                              : ((mag >= MagCap) ? (MagCap - VALUE_W'(1)) : mag);
            lst     = fin;
            cmd.pop = 1'b1;
            done_d  = fin;
            phase_d = PH_TYPE;
          end else if (kind_q == K_BULK) begin
            if (mag_neg) begin
              if (mag != VALUE_W'(1)) begin
                lock_d = 1'b1;
              end else begin
                ev      = EV_NULL;
                val     = '1;
                lst     = fin;
                cmd.pop = 1'b1;
                done_d  = fin;
                phase_d = PH_TYPE;
              end
            end else if (mag > VALUE_W'(max_bulk_q)) begin
              lock_d = 1'b1;
            end else begin
              ev      = EV_BULK_LEN;
              val     = mag;
              rem_d   = mag[BULK_W-1:0];
              phase_d = (mag == '0) ? PH_SKIP1 : PH_BULK;
            end
          end else begin
            if (mag_neg || mag > VALUE_W'(max_array_q)) begin
              lock_d = 1'b1;
            end else if (mag == '0) begin
              ev      = EV_ARRAY;
              lst     = fin;
              cmd.pop = 1'b1;
              done_d  = fin;
              phase_d = PH_TYPE;
            end else if (lvl >= LvlW'(NestDepth)) begin
              lock_d = 1'b1;
            end else begin
              ev        = EV_ARRAY;
              val       = mag;
              cmd.push  = 1'b1;
              cmd.count = mag[CNT_W-1:0];
              phase_d   = PH_TYPE;
            end
          end
        end
        PH_BULK: begin
          emit  = 1'b1;
          ev    = EV_BULK_BYTE;
          val   = VALUE_W'(in_byte_q);
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          phase_d = PH_SKIP2;
        end
        PH_SKIP2: begin
          emit    = 1'b1;
          ev      = EV_BULK_END;
          lst     = fin;
          cmd.pop = 1'b1;
          done_d  = fin;
          phase_d = PH_TYPE;
        end
        default: begin
          emit   = 1'b1;
          lock_d = 1'b1;
        end
      endcase
    end

    // Nothing reaches the stack unless the beat is processed.
    if (!proc) begin
      cmd = '0;
    end
  end

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_simple_q <= 8'd255;
      max_bulk_q   <= 32'd536870912;
      max_array_q  <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_SIMPLE: max_simple_q <= cfg_data_i[BYTE_W-1:0];
        CFG_MAX_BULK:   max_bulk_q   <= cfg_data_i[BULK_W-1:0];
        CFG_MAX_ARRAY:  max_array_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_sof_q  <= s_axis_tuser;
    end
  end

  // Parse state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= K_STR;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      dig_q   <= 1'b0;
      cc_q    <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
      lock_q  <= 1'b0;
    end else if (proc) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      dig_q   <= dig_d;
      cc_q    <= cc_d;
      rem_q   <= rem_d;
      done_q  <= done_d;
      lock_q  <= lock_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= proc && emit;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_data_q <= {dep, val, ev};
      out_last_q <= lst;
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the RESP stream tokenizer top level.
`timescale 1ns / 1ps

module tb;
  import rstok_pkg::*;

  localparam int unsigned OutW = EVENT_W + VALUE_W + DEPTH_W;
  localparam longint unsigned MagCap = 64'h8000_0000_0000_0000;

  typedef enum int {PH_TYPE, PH_SIMPLE, PH_SIMPLE_LF, PH_NUM, PH_NUM_LF, PH_BULK,
                    PH_SKIP1, PH_SKIP2} parse_phase_e;
  typedef enum int {K_STR, K_ERR, K_INT, K_BULK, K_ARR} elem_kind_e;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              som;
  } rx_byte_t;

  typedef struct {
    logic [EVENT_W-1:0] ev;
    logic [VALUE_W-1:0] val;
    logic [DEPTH_W-1:0] dep;
    logic               last;
  } resp_event_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [BYTE_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [OutW-1:0] m_axis_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  resp_stream_tokenizer_top dut (.*);

  // Byte stream waiting to be sent and events waiting to be seen.
  rx_byte_t    tx_bytes[$];
  resp_event_t event_fifo[$];
  bit          offer_held;
  int          send_idle_pct, recv_stall_pct, hold_cycles;
  int          n_fail, n_events, n_bytes;

  // Shadow copy of the limits and the parser state.
  logic [7:0]  lim_simple;
  logic [31:0] lim_bulk;
  logic [30:0] lim_array;
  parse_phase_e    ph;
  elem_kind_e      kind;
  longint unsigned acc;
  bit              neg, dseen, done, lock;
  int unsigned     ccount, lvl;
  logic [31:0]     brem;
  logic [31:0]     stack_cnt[NEST_DEPTH_DEF];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic push_event(input logic [EVENT_W-1:0] ev, input longint unsigned v,
                            input int unsigned d, input bit f);
    resp_event_t e;
    e.ev = ev; e.val = v; e.dep = d[DEPTH_W-1:0]; e.last = f;
    event_fifo.push_back(e);
  endtask

  task automatic flag_malformed();
    lock = 1;
    push_event(EV_BAD, 0, lvl, 1'b0);
  endtask

  // Close one element, unwinding finished arrays; returns 1 when the message is complete.
  function automatic bit close_element();
    while (lvl > 0 && lvl <= NEST_DEPTH_DEF) begin
      if (stack_cnt[lvl-1] > 0) stack_cnt[lvl-1]--;
      if (stack_cnt[lvl-1] != 0) begin
        ph = PH_TYPE;
        return 1'b0;
      end
      lvl--;
    end
    lvl = 0;
    ph = PH_TYPE;
    done = 1;
    return 1'b1;
  endfunction

  task automatic restart_parse();
    ph = PH_TYPE; kind = K_STR; acc = 0; neg = 0; dseen = 0; ccount = 0;
    brem = 0; lvl = 0; done = 0; lock = 0;
  endtask

  // Header number complete: integer, bulk length, null bulk or array count.
  task automatic finish_number();
    int unsigned d;
    bit isneg, f;
    d = lvl;
    isneg = neg && acc != 0;
    case (kind)
      K_INT: begin
        f = close_element();
        push_event(EV_INT, isneg ? (64'd0 - acc) : ((acc >= MagCap) ? MagCap - 1 : acc), d, f);
      end
      K_BULK: begin
        if (isneg) begin
          if (acc != 1) flag_malformed();
          else begin
            f = close_element();
            push_event(EV_NULL, '1, d, f);
          end
        end else if (acc > lim_bulk) flag_malformed();
        else begin
          brem = acc[31:0];
          ph = (acc == 0) ? PH_SKIP1 : PH_BULK;
          push_event(EV_BULK_LEN, acc, d, 1'b0);
        end
      end
      default: begin
        if (isneg || acc > lim_array) flag_malformed();
        else if (acc == 0) begin
          f = close_element();
          push_event(EV_ARRAY, 0, d, f);
        end else if (lvl >= NEST_DEPTH_DEF) flag_malformed();
        else begin
          stack_cnt[lvl] = acc[31:0];
          lvl++;
          ph = PH_TYPE;
          push_event(EV_ARRAY, acc, d, 1'b0);
        end
      end
    endcase
  endtask

  // Predict the event, if any, caused by one accepted byte.
  task automatic tokenize_byte(input logic [7:0] b, input logic som);
    bit f;
    int unsigned d;
    if (som) restart_parse();
    if (lock || done) return;
    case (ph)
      PH_TYPE: begin
        ccount = 0; acc = 0; neg = 0; dseen = 0;
        if (b == CH_PLUS || b == CH_MINUS) begin
          kind = (b == CH_PLUS) ? K_STR : K_ERR;
          ph = PH_SIMPLE;
        end else if (b == CH_COLON || b == CH_DOLLAR || b == CH_STAR) begin
          kind = (b == CH_COLON) ? K_INT : (b == CH_DOLLAR) ? K_BULK : K_ARR;
          ph = PH_NUM;
        end else flag_malformed();
      end
      PH_SIMPLE: begin
        if (b == CH_CR) begin
          if (ccount == 0) flag_malformed();
          else ph = PH_SIMPLE_LF;
        end else if (b == CH_LF) flag_malformed();
        else begin
          f = ccount < lim_simple;
          if (ccount < 255) ccount++;
          if (f) push_event((kind == K_ERR) ? EV_ERR_BYTE : EV_STR_BYTE, b, lvl, 1'b0);
        end
      end
      PH_SIMPLE_LF: begin
        if (b != CH_LF) flag_malformed();
        else begin
          d = lvl;
          f = close_element();
          push_event((kind == K_ERR) ? EV_ERR_END : EV_STR_END, 0, d, f);
        end
      end
      PH_NUM: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          if (acc > (MagCap - (b - CH_ZERO)) / 10) acc = MagCap;
          else acc = acc * 10 + (b - CH_ZERO);
          dseen = 1;
        end else if (b == CH_MINUS && !dseen && !neg) neg = 1;
        else if (b == CH_CR && dseen) ph = PH_NUM_LF;
        else flag_malformed();
      end
      PH_NUM_LF: begin
        if (b != CH_LF) flag_malformed();
        else finish_number();
      end
      PH_BULK: begin
        if (brem > 0) brem--;
        if (brem == 0) ph = PH_SKIP1;
        push_event(EV_BULK_BYTE, b, lvl, 1'b0);
      end
      PH_SKIP1: ph = PH_SKIP2;
      default: begin
        d = lvl;
        f = close_element();
        push_event(EV_BULK_END, 0, d, f);
      end
    endcase
  endtask

  // Sender: offer the head byte at the falling edge and hold it until taken.
  always @(negedge clk_i) begin
    if (!offer_held) begin
      if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_bytes[0].data;
        s_axis_tuser  <= tx_bytes[0].som;
        offer_held = 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Input beat taken: predict its event.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tokenize_byte(s_axis_tdata, s_axis_tuser);
      void'(tx_bytes.pop_front());
      offer_held = 0;
      n_bytes++;
    end
  end

  // Receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output beat: compare with the oldest predicted event.
  always @(posedge clk_i) begin
    resp_event_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_events++;
      if (event_fifo.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected event, expected none, actual ev=%0d val=%h dep=%0d last=%0b",
                 $time, m_axis_tdata[3:0], m_axis_tdata[67:4], m_axis_tdata[71:68],
                 m_axis_tlast);
      end else begin
        e = event_fifo.pop_front();
        if (m_axis_tdata[3:0] !== e.ev || m_axis_tdata[67:4] !== e.val ||
            m_axis_tdata[71:68] !== e.dep || m_axis_tlast !== e.last) begin
          n_fail++;
          $display("%0t: mismatch, expected ev=%0d val=%h dep=%0d last=%0b", $time,
                   e.ev, e.val, e.dep, e.last);
          $display("%0t:           actual   ev=%0d val=%h dep=%0d last=%0b", $time,
                   m_axis_tdata[3:0], m_axis_tdata[67:4], m_axis_tdata[71:68], m_axis_tlast);
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic som = 1'b0);
    rx_byte_t r;
    r.data = b; r.som = som;
    tx_bytes.push_back(r);
  endtask

  task automatic put_text(input string s, input bit som_first = 1'b0);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], som_first && i == 0);
  endtask

  // Random byte that is neither CR nor LF, with a small chance of either.
  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    b = $urandom_range(255);
    if ((b == CH_CR || b == CH_LF) && $urandom_range(3) != 0) b = 8'h41;
    return b;
  endfunction

  // Append one random element, nested arrays included, to the byte stream.
  task automatic gen_element(input int depth_now);
    int sel, n;
    longint unsigned mag;
    sel = $urandom_range(99);
    if (sel < 20) begin
      put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
      n = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) put_byte(content_byte());
      put_text("\r\n");
    end else if (sel < 40) begin
      put_byte(CH_COLON);
      case ($urandom_range(4))
        0: put_text("99999999999999999999");
        1: put_text("-0");
        2: put_text("-9223372036854775808");
        3: put_text($sformatf("%0d", {$urandom, $urandom}));
        default: put_text($sformatf("%0d", $signed($urandom_range(2000)) - 1000));
      endcase
      put_text("\r\n");
    end else if (sel < 62) begin
      put_byte(CH_DOLLAR);
      if ($urandom_range(7) == 0) put_text("-1\r\n");
      else begin
        n = $urandom_range(0, 5);
        put_text($sformatf("%0d\r\n", n));
        for (int i = 0; i < n; i++) put_byte($urandom_range(255));
        if ($urandom_range(1)) put_text("\r\n");
        else begin
          put_byte($urandom_range(255));
          put_byte($urandom_range(255));
        end
      end
    end else if (sel < 66) begin
      // Header that breaks the number syntax or the limits.
      put_byte($urandom_range(1) ? CH_DOLLAR : CH_STAR);
      case ($urandom_range(3))
        0: put_text("-2\r\n");
        1: put_text("12x\r\n");
        2: put_text("\r\n");
        default: put_text("4294967296\r\n");
      endcase
    end else if (sel < 70 && depth_now == 0) begin
      // Nine nested arrays overflow the stack.
      for (int i = 0; i < NEST_DEPTH_DEF + 1; i++) put_text("*1\r\n");
    end else if (depth_now < 4) begin
      n = $urandom_range(0, 3);
      put_text($sformatf("*%0d\r\n", n));
      for (int i = 0; i < n; i++) gen_element(depth_now + 1);
    end else begin
      put_text(":7\r\n");
    end
  endtask

  task automatic gen_message();
    int first_idx;
    first_idx = tx_bytes.size();
    gen_element(0);
    tx_bytes[first_idx].som = 1'b1;
    // Occasional corruption, restart mid-message or trailing junk after completion.
    if ($urandom_range(9) == 0)
      tx_bytes[$urandom_range(first_idx, tx_bytes.size() - 1)].data = $urandom_range(255);
    if ($urandom_range(14) == 0)
      tx_bytes[$urandom_range(first_idx, tx_bytes.size() - 1)].som = 1'b1;
    if ($urandom_range(9) == 0) put_byte($urandom_range(255));
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() > 0 || event_fifo.size() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_SIMPLE: lim_simple = v[7:0];
      CFG_MAX_BULK:   lim_bulk = v;
      default:        lim_array = v[30:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Main sequence: reset, directed bytes, then random phases with changing limits.
  initial begin
    int target;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; m_axis_tready = 0;
    cfg_valid_i = 0; cfg_index_i = CFG_MAX_SIMPLE; cfg_data_i = 0;
    offer_held = 0; hold_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    n_fail = 0; n_events = 0; n_bytes = 0;
    lim_simple = 8'd255; lim_bulk = 32'd536870912; lim_array = 31'h7FFF_FFFF;
    restart_parse();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: negative integer, empty simple string, bad type, null bulk, empty array, bad negative length.
    put_text(":-12\r\n", 1'b1);
    put_text("+\r", 1'b1);
    put_byte(8'h21, 1'b1);
    put_text("$-1\r\n", 1'b1);
    put_text("*0\r\n", 1'b1);
    put_text("$-2\r\n", 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          write_limit(CFG_MAX_SIMPLE, 1); write_limit(CFG_MAX_BULK, 0);
          write_limit(CFG_MAX_ARRAY, 0);
        end
        1: begin
          write_limit(CFG_MAX_SIMPLE, 255); write_limit(CFG_MAX_BULK, 32'hFFFF_FFFF);
          write_limit(CFG_MAX_ARRAY, 32'h7FFF_FFFF);
        end
        2: begin
          write_limit(CFG_MAX_SIMPLE, 3); write_limit(CFG_MAX_BULK, 3);
          write_limit(CFG_MAX_ARRAY, 2);
        end
        default: begin
          write_limit(CFG_MAX_SIMPLE, $urandom_range(1, 255));
          write_limit(CFG_MAX_BULK, $urandom_range(2, 6));
          write_limit(CFG_MAX_ARRAY, $urandom_range(1, 4));
        end
      endcase
      case (p / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      target = n_bytes + 140;
      while (tx_bytes.size() + n_bytes < target) gen_message();
      // Long receiver hold-off while bytes keep coming, so the input backs up.
      if (p == 1) hold_cycles = 200;
      wait_idle();
    end

    $display("Covered %0d input bytes and %0d events over eight limit settings", n_bytes,
             n_events);
    $display("and four idle/stall mixes, including a long output hold-off.");
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3ms;
    $display("Timeout with %0d bytes and %0d events outstanding", tx_bytes.size(),
             event_fifo.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rstok_pkg.sv
sv/rstok_stack.sv
sv/resp_stream_tokenizer_top.sv
verif/tb.sv
